// ===== rtl/wwr_pkg.sv =====
// Package for the whole word replacer: item and register types, constants,
// and the command and status bundles between the controller and datapath.
// Depends on nothing.
package wwr_pkg;

    // Longest word held in the word buffer, in bytes.
    localparam int WORD_MAX = 8;
    localparam int BUF_W    = WORD_MAX * 8;

    // Byte counts of words and the replacement; the length registers are 4 bits.
    localparam int CNT_W    = 4;
    localparam int REPL_MAX = 8;
    localparam int SHIFT_W  = REPL_MAX * 8;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Configuration port: 64-bit data, register i at byte address 8*i.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_sentence;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       any_replaced;
    } out_item_t;

    typedef struct packed {
        logic [63:0]      pattern_bytes;
        logic [CNT_W-1:0] pattern_length;
        logic [63:0]      replacement_bytes;
        logic [CNT_W-1:0] replacement_length;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic emit_word;
        logic emit_tail;
        logic emit_null;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_word;   // captured item has buffered or replacement bytes to send
        logic has_tail;   // captured item has a trailing byte to send
        logic need_null;  // captured item ends the sentence with nothing to send
        logic word_last;  // one word byte left in the output shifter
        logic tail_pend;  // trailing byte still waiting
        logic out_free;   // output register can take a byte this cycle
    } dp_status_t;

endpackage

// ===== rtl/wwr_regs.sv =====
// Configuration register file of the whole word replacer, behind an APB-style port.
// Depends on wwr_pkg.
module wwr_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wwr_pkg::ADDR_W-1:0] paddr,
    input  logic [wwr_pkg::DATA_W-1:0] pwdata,
    output logic [wwr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output wwr_pkg::cfg_t              cfg
);

    logic [63:0]               pattern_bytes_reg;
    logic [wwr_pkg::CNT_W-1:0] pattern_length_reg;
    logic [63:0]               replacement_bytes_reg;
    logic [wwr_pkg::CNT_W-1:0] replacement_length_reg;
    logic                      wr_en;
    logic [1:0]                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                wwr_pkg::REG_PATTERN_BYTES:      pattern_bytes_reg      <= pwdata[63:0];
                wwr_pkg::REG_PATTERN_LENGTH:     pattern_length_reg     <= pwdata[3:0];
                wwr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= pwdata[63:0];
                wwr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wwr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes_reg;
            wwr_pkg::REG_PATTERN_LENGTH:     prdata = 64'(pattern_length_reg);
            wwr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_reg;
            wwr_pkg::REG_REPLACEMENT_LENGTH: prdata = 64'(replacement_length_reg);
            default:                         prdata = '0;
        endcase
    end

    assign cfg.pattern_bytes      = pattern_bytes_reg;
    assign cfg.pattern_length     = pattern_length_reg;
    assign cfg.replacement_bytes  = replacement_bytes_reg;
    assign cfg.replacement_length = replacement_length_reg;

endmodule

// ===== rtl/wwr_ctrl.sv =====
// Controller of the whole word replacer: sequences capture of an item and
// the emission of its word bytes, trailing byte and empty-sentence marker.
// Depends on wwr_pkg.
module wwr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    input  wwr_pkg::dp_status_t status,
    output wwr_pkg::ctrl_cmd_t  cmd,
    output logic                text_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORD = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_NULL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        text_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                text_stall = 1'b0;
                if (text_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.has_word)
                        state_next = S_WORD;
                    else if (status.has_tail)
                        state_next = S_TAIL;
                    else if (status.need_null)
                        state_next = S_NULL;
                end
            end
            S_WORD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    if (status.word_last)
                        state_next = status.tail_pend ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_tail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_NULL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_null = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/wwr_dp.sv =====
// Datapath of the whole word replacer: word buffer, pattern compare, output
// shifter, trailing byte and the output register.
// Depends on wwr_pkg.
module wwr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  wwr_pkg::cfg_t       cfg,
    input  wwr_pkg::in_item_t   text_item,
    input  wwr_pkg::ctrl_cmd_t  cmd,
    input  logic                edit_stall,
    output wwr_pkg::out_item_t  edit_item,
    output logic                edit_valid,
    output wwr_pkg::dp_status_t status
);

    // Sentence state.
    logic [wwr_pkg::BUF_W-1:0]   word_buf_reg;
    logic [wwr_pkg::CNT_W-1:0]   word_count_reg;
    logic                        passing_reg;
    logic                        replaced_reg;
    // Emission state of the captured item.
    logic [wwr_pkg::SHIFT_W-1:0] shift_reg;
    logic [wwr_pkg::CNT_W-1:0]   shift_cnt_reg;
    logic                        tail_valid_reg;
    logic [7:0]                  tail_byte_reg;
    logic                        eos_reg;
    logic                        anyrep_reg;
    // Output register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    wwr_pkg::out_item_t          out_item_reg;
    wwr_pkg::out_item_t          out_item_next;

    logic                        is_space;
    logic                        eos;
    logic                        case_store;
    logic                        case_over;
    logic [wwr_pkg::BUF_W-1:0]   buf_w;
    logic [wwr_pkg::CNT_W-1:0]   fin_cnt;
    logic                        finish;
    logic                        mismatch;
    logic                        match;
    logic [wwr_pkg::CNT_W-1:0]   rep_len;
    logic [wwr_pkg::CNT_W-1:0]   load_cnt;
    logic [wwr_pkg::SHIFT_W-1:0] load_data;
    logic                        has_tail;
    logic                        replaced_now;
    logic                        word_last_byte;

    assign is_space   = (text_item.text_byte == wwr_pkg::SPACE_BYTE);
    assign eos        = text_item.end_of_sentence;
    assign case_store = !is_space && !passing_reg &&
                        (word_count_reg < wwr_pkg::CNT_W'(wwr_pkg::WORD_MAX));
    assign case_over  = !is_space && !passing_reg &&
                        !(word_count_reg < wwr_pkg::CNT_W'(wwr_pkg::WORD_MAX));

    // Buffer with the incoming byte written, and the masked pattern compare.
    always_comb
    begin
        buf_w    = word_buf_reg;
        mismatch = 1'b0;
        for (int i = 0; i < wwr_pkg::WORD_MAX; i++)
        begin
            if (case_store && (word_count_reg == wwr_pkg::CNT_W'(i)))
                buf_w[8*i +: 8] = text_item.text_byte;
        end
        for (int i = 0; i < wwr_pkg::WORD_MAX; i++)
        begin
            if ((wwr_pkg::CNT_W'(i) < fin_cnt) &&
                (buf_w[8*i +: 8] != cfg.pattern_bytes[8*i +: 8]))
                mismatch = 1'b1;
        end
    end

    assign fin_cnt  = case_store ? word_count_reg + 1'b1 : word_count_reg;
    assign finish   = (is_space && !passing_reg && (word_count_reg != '0)) ||
                      (case_store && eos);
    assign match    = (fin_cnt != '0) && (fin_cnt == cfg.pattern_length) && !mismatch;
    assign rep_len  = (cfg.replacement_length > wwr_pkg::CNT_W'(wwr_pkg::REPL_MAX)) ?
                      wwr_pkg::CNT_W'(wwr_pkg::REPL_MAX) : cfg.replacement_length;

    always_comb
    begin
        if (finish)
            load_cnt = match ? rep_len : fin_cnt;
        else if (case_over)
            load_cnt = word_count_reg;
        else
            load_cnt = '0;
    end

    assign load_data    = (finish && match) ? cfg.replacement_bytes :
                          wwr_pkg::SHIFT_W'(buf_w);
    assign has_tail     = !case_store;
    assign replaced_now = replaced_reg | (finish & match);

    assign status.has_word  = (load_cnt != '0);
    assign status.has_tail  = has_tail;
    assign status.need_null = eos && (load_cnt == '0) && !has_tail;
    assign status.word_last = (shift_cnt_reg == wwr_pkg::CNT_W'(1));
    assign status.tail_pend = tail_valid_reg;
    assign status.out_free  = !out_valid_reg || !edit_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            passing_reg    <= 1'b0;
            replaced_reg   <= 1'b0;
            shift_cnt_reg  <= '0;
            tail_valid_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            word_count_reg <= (case_store && !eos) ? word_count_reg + 1'b1 : '0;
            passing_reg    <= eos ? 1'b0 : (case_over ? 1'b1 :
                              (is_space ? 1'b0 : passing_reg));
            replaced_reg   <= eos ? 1'b0 : replaced_now;
            shift_cnt_reg  <= load_cnt;
            tail_valid_reg <= has_tail;
        end
        else
        begin
            if (cmd.emit_word)
                shift_cnt_reg <= shift_cnt_reg - 1'b1;
            if (cmd.emit_tail)
                tail_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_buf_reg  <= buf_w;
            shift_reg     <= load_data;
            tail_byte_reg <= text_item.text_byte;
            eos_reg       <= eos;
            anyrep_reg    <= replaced_now;
        end
        else if (cmd.emit_word)
        begin
            shift_reg <= shift_reg >> 8;
        end
    end

    // Next byte for the output register.
    assign word_last_byte = eos_reg && status.word_last && !tail_valid_reg;

    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && edit_stall;
        if (cmd.emit_word)
        begin
            out_item_next.out_byte     = shift_reg[7:0];
            out_item_next.out_last     = word_last_byte;
            out_item_next.any_replaced = word_last_byte & anyrep_reg;
            out_valid_next             = 1'b1;
        end
        else if (cmd.emit_tail)
        begin
            out_item_next.out_byte     = tail_byte_reg;
            out_item_next.out_last     = eos_reg;
            out_item_next.any_replaced = eos_reg & anyrep_reg;
            out_valid_next             = 1'b1;
        end
        else if (cmd.emit_null)
        begin
            out_item_next.out_byte     = 8'h00;
            out_item_next.out_last     = 1'b1;
            out_item_next.any_replaced = anyrep_reg;
            out_valid_next             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign edit_valid = out_valid_reg;
    assign edit_item  = out_item_reg;

`ifndef ASSERT_OFF
    // A byte is never loaded into an output register that is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && edit_stall) |-> !(cmd.emit_word || cmd.emit_tail || cmd.emit_null))
        else $error("output register overwritten while stalled");

    // The shifter is only drained while it holds bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_word |-> (shift_cnt_reg != '0))
        else $error("word byte emitted from an empty shifter");

    // An overlong word in flight leaves the buffer empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        passing_reg |-> (word_count_reg == '0))
        else $error("word buffer not empty while passing a long word");

    // The end of a sentence clears all sentence state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && eos) |=> (word_count_reg == '0) && !passing_reg && !replaced_reg)
        else $error("sentence state not cleared at sentence end");
`endif

endmodule

// ===== rtl/whole_word_replacer.sv =====
// Top level of the whole word replacer: register file, controller and datapath.
// Depends on wwr_pkg, wwr_regs, wwr_ctrl and wwr_dp.
//
// The block takes a sentence one byte at a time on the text channel and sends
// the edited sentence on the edit channel, replacing every whole word equal to
// the pattern register with the replacement register. Only the space byte
// separates words; the start and end of the sentence are boundaries too.
// Non-space bytes are held in an eight-byte word buffer until the word ends;
// a ninth byte of a word flushes the buffer and the rest of that word passes
// through unchanged. Inserted text is not scanned again. The final byte of the
// sentence carries out_last, and any_replaced on it tells whether any word was
// replaced. If the last item would produce no byte (the last word replaced by
// an empty replacement), a single 0x00 byte with out_last is sent instead.
// Timing: an item is taken while the controller is idle, after which the output
// register sends its results at one byte per cycle as long as the edit channel
// does not stall. The text channel is stalled while the results of the previous
// item are still being sent, but a new item is taken while the last result waits
// in the output register. Registers are written over the APB-style port at byte
// addresses 0, 8, 16 and 24 (pattern bytes, pattern length, replacement bytes,
// replacement length) and should be written only while the block is idle.
module whole_word_replacer (
    input  logic                       clk,
    input  logic                       rst_n,
    // Text channel.
    input  logic                       text_valid,
    output logic                       text_stall,
    input  wwr_pkg::in_item_t          text_item,
    // Edit channel.
    output logic                       edit_valid,
    input  logic                       edit_stall,
    output wwr_pkg::out_item_t         edit_item,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wwr_pkg::ADDR_W-1:0] paddr,
    input  logic [wwr_pkg::DATA_W-1:0] pwdata,
    output logic [wwr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    wwr_pkg::cfg_t       cfg;
    wwr_pkg::ctrl_cmd_t  cmd;
    wwr_pkg::dp_status_t status;

    wwr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller decides when an item is taken and which byte goes out next.
    wwr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .status     (status),
        .cmd        (cmd),
        .text_stall (text_stall)
    );

    // The datapath holds the word, compares it and drives the output register.
    wwr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text_item  (text_item),
        .cmd        (cmd),
        .edit_stall (edit_stall),
        .edit_item  (edit_item),
        .edit_valid (edit_valid),
        .status     (status)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the whole word replacer: directed table, then random sentences.
// Depends on wwr_pkg and whole_word_replacer; everything else is local to this file.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // A stretch of this many cycles with no accepted item on any channel and no
    // register access means the block has hung. The longest legal quiet stretch is
    // the receiver hold-off plus the settling time before a write.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last expected item before a register write or the end.
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 14;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       text_valid = 1'b0;
    logic                       text_stall;
    wwr_pkg::in_item_t          text_item = '0;
    logic                       edit_valid;
    logic                       edit_stall = 1'b0;
    wwr_pkg::out_item_t         edit_item;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [wwr_pkg::ADDR_W-1:0] paddr = '0;
    logic [wwr_pkg::DATA_W-1:0] pwdata = '0;
    logic [wwr_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    whole_word_replacer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .edit_valid (edit_valid),
        .edit_stall (edit_stall),
        .edit_item  (edit_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the testbench's own copy of the registers and of the
    // word buffer, updated once per accepted text item.
    // ------------------------------------------------------------------
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = 4'd0;

    logic [7:0]  word_buf [wwr_pkg::WORD_MAX];
    int          word_len      = 0;
    logic        long_word     = 1'b0;
    logic        replaced_seen = 1'b0;

    // Edit items caused by the item being predicted, and every edit item still owed.
    wwr_pkg::out_item_t step_q [$];
    wwr_pkg::out_item_t edit_expect_q [$];

    int          errors        = 0;
    int          text_count    = 0;
    int          edit_count    = 0;
    int          reg_writes    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_cycles   = 0;
    int          idle_run      = 0;

    task automatic emit_byte(input logic [7:0] b);
        step_q.push_back('{b, 1'b0, 1'b0});
    endtask

    // At the end of a word either the replacement or the buffered bytes go out.
    // An empty word is never compared, and a pattern length outside one to eight
    // can never equal a word length, so it never matches.
    task automatic close_word();
        logic hit;
        int   n;
        if (word_len == 0)
            return;
        hit = (int'(pat_len) == word_len);
        for (int i = 0; i < word_len; i++)
            if (word_buf[i] != pat_bytes[8*i +: 8])
                hit = 1'b0;
        if (hit)
        begin
            // Lengths above eight are clipped to the eight-byte replacement.
            n = (rep_len > 4'd8) ? 8 : int'(rep_len);
            for (int i = 0; i < n; i++)
                emit_byte(rep_bytes[8*i +: 8]);
            replaced_seen = 1'b1;
        end
        else
        begin
            for (int i = 0; i < word_len; i++)
                emit_byte(word_buf[i]);
        end
        word_len = 0;
    endtask

    task automatic predict_edit(input wwr_pkg::in_item_t it);
        step_q.delete();
        if (it.text_byte == wwr_pkg::SPACE_BYTE)
        begin
            // A space ends the word; after an overlong word it only clears the
            // pass-through mode, since those bytes have already gone out.
            if (long_word)
                long_word = 1'b0;
            else
                close_word();
            emit_byte(it.text_byte);
        end
        else if (long_word)
        begin
            emit_byte(it.text_byte);
        end
        else if (word_len < wwr_pkg::WORD_MAX)
        begin
            word_buf[word_len] = it.text_byte;
            word_len++;
            if (it.end_of_sentence)
                close_word();
        end
        else
        begin
            // Buffer overflow: flush the eight held bytes, then this one, and let
            // the rest of the word pass straight through.
            for (int i = 0; i < word_len; i++)
                emit_byte(word_buf[i]);
            emit_byte(it.text_byte);
            word_len  = 0;
            long_word = 1'b1;
        end
        if (it.end_of_sentence)
        begin
            // A sentence that ends with nothing to send still gets a NUL byte so
            // that out_last has an item to ride on.
            if (step_q.size() == 0)
                emit_byte(8'h00);
            step_q[step_q.size()-1].out_last     = 1'b1;
            step_q[step_q.size()-1].any_replaced = replaced_seen;
            word_len      = 0;
            long_word     = 1'b0;
            replaced_seen = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers. Inputs change at the falling edge; handshakes are sampled at the
    // rising edge. Every driver task is entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (edit_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // Offers one text item and holds it until accepted. A fixed_n of -1 means the
    // expected edit items come from the predictor; 0 or 1 means they were typed
    // into the directed table, in which case the predictor only tracks state.
    task automatic send_text(input wwr_pkg::in_item_t it, input int fixed_n,
                             input wwr_pkg::out_item_t fixed);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= it;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        predict_edit(it);
        if (fixed_n < 0)
        begin
            foreach (step_q[i])
                edit_expect_q.push_back(step_q[i]);
        end
        else if (fixed_n == 1)
        begin
            edit_expect_q.push_back(fixed);
        end
        text_count++;
        @(negedge clk);
    endtask

    // Registers are written only with the block idle: the text channel quiet,
    // every owed edit item delivered, and a settling wait after that for an item
    // that caused no output yet.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        text_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            wwr_pkg::REG_PATTERN_BYTES:      pat_bytes = val;
            wwr_pkg::REG_PATTERN_LENGTH:     pat_len   = val[3:0];
            wwr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes = val;
            wwr_pkg::REG_REPLACEMENT_LENGTH: rep_len   = val[3:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] nonspace_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == wwr_pkg::SPACE_BYTE)
            b = b ^ 8'h01;
        return b;
    endfunction

    // One random sentence. Most are well-formed: words separated by runs of
    // spaces, many equal to the pattern, some one byte short or long, some random
    // and up to twelve bytes so the buffer overflows. The rest is raw noise with
    // stray spaces and sentence ends anywhere.
    task automatic send_sentence();
        wwr_pkg::in_item_t s [$];
        int                nw;
        int                kind;
        int                wl;
        int                eff;
        int                w;
        int                k;
        logic [7:0]        b;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 10))
            begin
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    b = wwr_pkg::SPACE_BYTE;
                s.push_back('{b, 1'($urandom_range(0, 9) == 0)});
            end
        end
        else
        begin
            nw  = $urandom_range(1, 5);
            eff = (pat_len >= 4'd1 && pat_len <= 4'd8) ? int'(pat_len) : 8;
            for (w = 0; w < nw; w++)
            begin
                if (w > 0 || $urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) s.push_back('{wwr_pkg::SPACE_BYTE, 1'b0});
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    if (kind < 4)
                        wl = eff;
                    else if (kind == 4 && eff > 1)
                        wl = eff - 1;
                    else
                        wl = eff + 1;
                    for (k = 0; k < wl; k++)
                        s.push_back('{(k < eff) ? pat_bytes[8*k +: 8] : nonspace_byte(), 1'b0});
                end
                else
                begin
                    repeat ($urandom_range(1, 12)) s.push_back('{nonspace_byte(), 1'b0});
                end
            end
            if ($urandom_range(0, 4) == 0)
                s.push_back('{wwr_pkg::SPACE_BYTE, 1'b0});
            s[s.size()-1].end_of_sentence = 1'b1;
        end
        foreach (s[i])
            send_text(s[i], -1, '0);
    endtask

    // Each random phase writes all four registers; the first four phases take the
    // extremes: a NUL pattern with empty replacement, all-ones words of eight
    // bytes, a zero pattern length, and an over-range pattern length.
    task automatic random_config(input int p);
        logic [63:0] pb;
        logic [63:0] rb;
        logic [3:0]  pl;
        logic [3:0]  rl;
        for (int i = 0; i < 8; i++)
            pb[8*i +: 8] = nonspace_byte();
        rb = {$urandom, $urandom};
        pl = 4'($urandom_range(1, 8));
        rl = 4'($urandom_range(0, 8));
        case (p)
            0:
            begin
                pb = '0;
                pl = 4'd1;
                rb = '0;
                rl = 4'd0;
            end
            1:
            begin
                pb = '1;
                pl = 4'd8;
                rb = '1;
                rl = 4'd8;
            end
            2:
            begin
                pl = 4'd0;
                rl = 4'd15;
            end
            3:
            begin
                pl = 4'd15;
                rl = 4'd9;
            end
            default: ;
        endcase
        write_reg(wwr_pkg::REG_PATTERN_BYTES, pb);
        write_reg(wwr_pkg::REG_PATTERN_LENGTH, 64'(pl));
        write_reg(wwr_pkg::REG_REPLACEMENT_BYTES, rb);
        write_reg(wwr_pkg::REG_REPLACEMENT_LENGTH, 64'(rl));
    endtask

    // ------------------------------------------------------------------
    // Directed table. A row is either a register write or a text item; text rows
    // carry typed expectations only where the answer is obvious.
    // ------------------------------------------------------------------
    typedef enum int { ROW_TEXT, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [63:0]        value;
        wwr_pkg::in_item_t  item;
        int                 fixed_n;
        wwr_pkg::out_item_t fixed;
    } row_t;

    row_t dir_rows [$];

    function automatic row_t txt_row(input logic [7:0] b, input logic eos);
        return '{ROW_TEXT, wwr_pkg::REG_PATTERN_BYTES, 64'h0, '{b, eos}, -1, '0};
    endfunction

    function automatic row_t fix_row(input logic [7:0] b, input logic eos, input int n,
                                     input logic [7:0] ob, input logic last, input logic rep);
        return '{ROW_TEXT, wwr_pkg::REG_PATTERN_BYTES, 64'h0, '{b, eos}, n, '{ob, last, rep}};
    endfunction

    function automatic row_t reg_row(input logic [1:0] idx, input logic [63:0] val);
        return '{ROW_REG, idx, val, '0, -1, '0};
    endfunction

    task automatic build_table();
        // After reset the pattern is one NUL byte and the replacement is empty, so
        // a lone NUL at the sentence end leaves nothing and a NUL is sent instead.
        dir_rows.push_back(fix_row(8'h00, 1'b1, 1, 8'h00, 1'b1, 1'b1));
        dir_rows.push_back(fix_row(8'hFF, 1'b1, 1, 8'hFF, 1'b1, 1'b0));
        dir_rows.push_back(fix_row(wwr_pkg::SPACE_BYTE, 1'b1, 1, wwr_pkg::SPACE_BYTE,
                                   1'b1, 1'b0));
        // A word byte alone is only buffered.
        dir_rows.push_back(fix_row(8'h41, 1'b0, 0, 8'h00, 1'b0, 1'b0));
        // Consecutive spaces each pass through; the second closes an empty word.
        dir_rows.push_back(txt_row(wwr_pkg::SPACE_BYTE, 1'b0));
        dir_rows.push_back(txt_row(wwr_pkg::SPACE_BYTE, 1'b0));
        dir_rows.push_back(txt_row(8'h00, 1'b1));
        // Pattern "cat", replacement "ABCDEFGH" with an over-range length of 15.
        dir_rows.push_back(reg_row(wwr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0074_6163));
        dir_rows.push_back(reg_row(wwr_pkg::REG_PATTERN_LENGTH, 64'd3));
        dir_rows.push_back(reg_row(wwr_pkg::REG_REPLACEMENT_BYTES, 64'h4847_4645_4443_4241));
        dir_rows.push_back(reg_row(wwr_pkg::REG_REPLACEMENT_LENGTH, 64'd15));
        dir_rows.push_back(txt_row(8'h63, 1'b0));
        dir_rows.push_back(txt_row(8'h61, 1'b0));
        dir_rows.push_back(txt_row(8'h74, 1'b0));
        dir_rows.push_back(txt_row(wwr_pkg::SPACE_BYTE, 1'b0));
        // Ten-byte word: the ninth byte flushes nine items, the tenth passes through.
        for (int i = 0; i < 10; i++)
            dir_rows.push_back(txt_row(8'h61 + 8'(i), 1'b0));
        dir_rows.push_back(txt_row(wwr_pkg::SPACE_BYTE, 1'b1));
        // A zero pattern length never matches, even the word "cat".
        dir_rows.push_back(reg_row(wwr_pkg::REG_PATTERN_LENGTH, 64'd0));
        dir_rows.push_back(txt_row(8'h63, 1'b0));
        dir_rows.push_back(txt_row(8'h61, 1'b0));
        dir_rows.push_back(txt_row(8'h74, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Edit channel: stall at random per phase, or hold off for a counted stretch.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            edit_stall <= 1'b1;
        end
        else
        begin
            edit_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic report(input string field, input logic [7:0] want_v, input logic [7:0] got_v);
        errors++;
        $display("%0t ns: %s differs, expected 0x%02h, actual 0x%02h", $time, field, want_v, got_v);
    endtask

    // Every accepted edit item is compared field by field with the oldest owed one.
    always @(posedge clk)
    begin : edit_check
        wwr_pkg::out_item_t want;
        if (rst_n && edit_valid && !edit_stall)
        begin
            edit_count++;
            if (edit_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: edit item with none expected, actual %p", $time, edit_item);
            end
            else
            begin
                want = edit_expect_q.pop_front();
                if (edit_item.out_byte !== want.out_byte)
                    report("out_byte", want.out_byte, edit_item.out_byte);
                if (edit_item.out_last !== want.out_last)
                    report("out_last", 8'(want.out_last), 8'(edit_item.out_last));
                if (edit_item.any_replaced !== want.any_replaced)
                    report("any_replaced", 8'(want.any_replaced), 8'(edit_item.any_replaced));
            end
        end
    end

    // Watchdog: quiet cycles on every channel are counted; a long run ends the test.
    always @(posedge clk)
    begin
        if ((text_valid && !text_stall) || (edit_valid && !edit_stall) || psel)
            idle_run = 0;
        else
            idle_run = idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles at %0t ns", idle_run, $time);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int phase_end;
        build_table();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows run without idling so the table reads as a plain sequence.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
                send_text(dir_rows[i].item, dir_rows[i].fixed_n, dir_rows[i].fixed);
        end

        // Random phases cycle through the idling modes: none, sender idle,
        // receiver stalling, both.
        for (int p = 0; p < PHASES; p++)
        begin
            random_config(p);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 46;
                end
                default:
                begin
                    send_idle_pct = 27;
                    stall_pct     = 27;
                end
            endcase
            // In one phase the receiver holds off long enough that the block fills
            // and stalls the text channel while items keep being offered.
            if (p == 4)
            begin
                @(posedge clk);
                hold_cycles = 150;
                @(negedge clk);
            end
            phase_end = text_count + PHASE_ITEMS;
            while (text_count < phase_end)
            begin
                // In another phase the sender waits for every owed item before
                // each sentence, so the block runs dry between sentences.
                if (p == 6)
                begin
                    text_valid <= 1'b0;
                    @(negedge clk);
                    wait_drained();
                end
                send_sentence();
            end
        end

        text_valid <= 1'b0;
        hold_cycles = 0;
        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("Covered %0d text items and %0d edit items with %0d register writes,",
                 text_count, edit_count, reg_writes);
        $display("across %0d register settings and four idling modes.", PHASES + 3);
        if (errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
